// ----- sv/tepq_pkg.sv -----
package tepq_pkg;

	// Fixed sizes of the queue and of one stored event
	localparam int CAPACITY  = 16;
	localparam int TIME_BITS = 32;
	localparam int KIND_BITS = 8;
	localparam int CNT_BITS  = $clog2(CAPACITY + 1);
	localparam int PTR_BITS  = $clog2(CAPACITY);

	localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(CAPACITY - 1);
	localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(CAPACITY);

	// Request codes
	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_POP    = 2'd1;
	localparam logic [1:0] REQ_QUERY  = 2'd2;

	typedef struct packed {
		logic [1:0]           req_type;
		logic [KIND_BITS-1:0] event_kind;
		logic [TIME_BITS-1:0] event_due;
		logic [TIME_BITS-1:0] now_time;
	} req_t;

	typedef struct packed {
		logic                 out_valid;
		logic [KIND_BITS-1:0] out_kind;
		logic [TIME_BITS-1:0] out_due;
		logic                 head_ready;
		logic [CNT_BITS-1:0]  entry_total;
		logic                 is_empty;
		logic                 insert_dropped;
	} rsp_t;

	// One stored event
	typedef struct packed {
		logic [KIND_BITS-1:0] kind;
		logic [TIME_BITS-1:0] due;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_WALK,
		ST_INS_PUT,
		ST_POP_RD,
		ST_POP_LD,
		ST_DONE
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;
		logic ins_start;
		logic walk;
		logic put;
		logic pop_start;
		logic pop_load;
		logic finish;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic count_zero;
		logic full;
		logic walk_greater;
		logic walk_last;
		logic rsp_free;
	} sts_t;

	// Circular slot pointer steps
	function automatic logic [PTR_BITS-1:0] ptr_next(input logic [PTR_BITS-1:0] p);
		return (p == PTR_LAST) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [PTR_BITS-1:0] ptr_prev(input logic [PTR_BITS-1:0] p);
		return (p == '0) ? PTR_LAST : p - 1'b1;
	endfunction

endpackage

// ----- sv/tepq_ram.sv -----
module tepq_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- sv/tepq_ctrl.sv -----
module tepq_ctrl
	import tepq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic [1:0] req_type,
	input  sts_t       sts,
	output logic       req_ready,
	output cmd_t       cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					case (req_type)
						REQ_INSERT: state_d = sts.full ? ST_DONE : ST_INS_RD;
						REQ_POP:    state_d = sts.count_zero ? ST_DONE : ST_POP_RD;
						default:    state_d = ST_DONE;
					endcase
				end
			end
			ST_INS_RD:   state_d = sts.count_zero ? ST_DONE : ST_INS_WALK;
			ST_INS_WALK: begin
				if (!sts.walk_greater) begin
					state_d = ST_DONE;
				end else if (sts.walk_last) begin
					state_d = ST_INS_PUT;
				end
			end
			ST_INS_PUT:  state_d = ST_DONE;
			ST_POP_RD:   state_d = ST_POP_LD;
			ST_POP_LD:   state_d = ST_DONE;
			ST_DONE:     state_d = sts.rsp_free ? ST_IDLE : ST_DONE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready   = 1'b1;
				cmd.capture = req_valid;
			end
			ST_INS_RD:   cmd.ins_start = 1'b1;
			ST_INS_WALK: cmd.walk      = 1'b1;
			ST_INS_PUT:  cmd.put       = 1'b1;
			ST_POP_RD:   cmd.pop_start = 1'b1;
			ST_POP_LD:   cmd.pop_load  = 1'b1;
			ST_DONE:     cmd.finish    = sts.rsp_free;
			default:     cmd           = '0;
		endcase
	end

endmodule

// ----- sv/tepq_dpath.sv -----
module tepq_dpath
	import tepq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  req_t req_data,
	input  cmd_t cmd,
	output sts_t sts,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp_data
);

	// Control registers
	logic [CNT_BITS-1:0] count_q;
	logic [PTR_BITS-1:0] head_ptr_q;
	logic [PTR_BITS-1:0] tail_ptr_q;
	logic                rsp_full_q;

	// Payload registers
	req_t                req_q;
	logic                drop_q;
	logic                pop_hit_q;
	entry_t              pop_entry_q;
	entry_t              head_q;
	logic [PTR_BITS-1:0] kp_q;
	logic [PTR_BITS-1:0] wp_q;
	logic [PTR_BITS-1:0] k_q;
	rsp_t                rsp_q;

	// Slot memory
	logic                ram_we;
	logic [PTR_BITS-1:0] ram_waddr;
	logic [PTR_BITS-1:0] ram_raddr;
	entry_t              ram_wdata;
	entry_t              ram_rdata;
	entry_t              new_entry;
	logic                first_write;
	logic                walk_greater;
	logic                nonempty;
	logic                is_pop;
	rsp_t                rsp_d;

	assign new_entry    = '{kind: req_q.event_kind, due: req_q.event_due};
	assign nonempty     = (count_q != '0);
	assign first_write  = cmd.ins_start && !nonempty;
	assign walk_greater = (ram_rdata.due > req_q.event_due);
	assign is_pop       = (req_q.req_type == REQ_POP);

	assign sts.count_zero   = !nonempty;
	assign sts.full         = (count_q >= CNT_FULL);
	assign sts.walk_greater = walk_greater;
	assign sts.walk_last    = (k_q == '0);
	assign sts.rsp_free     = !rsp_full_q || rsp_ready;

	// Memory port selection
	always_comb begin
		ram_we    = first_write || cmd.walk || cmd.put;
		ram_waddr = (cmd.walk || cmd.put) ? wp_q : tail_ptr_q;
		ram_wdata = (cmd.walk && walk_greater) ? ram_rdata : new_entry;
		if (cmd.ins_start) begin
			ram_raddr = ptr_prev(tail_ptr_q);
		end else if (cmd.walk) begin
			ram_raddr = ptr_prev(kp_q);
		end else begin
			ram_raddr = ptr_next(head_ptr_q);
		end
	end

	tepq_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Count and ring pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			head_ptr_q <= '0;
			tail_ptr_q <= '0;
		end else if (cmd.ins_start) begin
			count_q    <= count_q + 1'b1;
			tail_ptr_q <= ptr_next(tail_ptr_q);
		end else if (cmd.pop_start) begin
			count_q    <= count_q - 1'b1;
			head_ptr_q <= ptr_next(head_ptr_q);
		end
	end

	// Transaction capture, insertion walk and head mirror
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q     <= req_data;
			drop_q    <= (req_data.req_type == REQ_INSERT) && sts.full;
			pop_hit_q <= 1'b0;
		end
		if (cmd.ins_start) begin
			kp_q <= ptr_prev(tail_ptr_q);
			wp_q <= tail_ptr_q;
			k_q  <= PTR_BITS'(count_q - 1'b1);
		end
		if (cmd.walk && walk_greater) begin
			wp_q <= kp_q;
			kp_q <= ptr_prev(kp_q);
			k_q  <= k_q - 1'b1;
		end
		if (first_write || cmd.put) begin
			head_q <= new_entry;
		end else if (cmd.pop_load) begin
			head_q <= ram_rdata;
		end
		if (cmd.pop_start) begin
			pop_hit_q   <= 1'b1;
			pop_entry_q <= head_q;
		end
		if (cmd.finish) begin
			rsp_q <= rsp_d;
		end
	end

	// Result fields
	always_comb begin
		rsp_d.out_valid      = is_pop ? pop_hit_q : nonempty;
		rsp_d.out_kind       = '0;
		rsp_d.out_due        = '0;
		if (is_pop && pop_hit_q) begin
			rsp_d.out_kind = pop_entry_q.kind;
			rsp_d.out_due  = pop_entry_q.due;
		end else if (!is_pop && nonempty) begin
			rsp_d.out_kind = head_q.kind;
			rsp_d.out_due  = head_q.due;
		end
		rsp_d.head_ready     = nonempty && (head_q.due <= req_q.now_time);
		rsp_d.entry_total    = count_q;
		rsp_d.is_empty       = !nonempty;
		rsp_d.insert_dropped = drop_q;
	end

	// Output register occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_full_q <= 1'b0;
		end else if (cmd.finish) begin
			rsp_full_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_full_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_full_q;
	assign rsp_data  = rsp_q;

endmodule

// ----- sv/timed_event_priority_queue_top.sv -----
// Channel   Direction  Handshake             Payload
// request   in         req_valid/req_ready   req_data  (req_t)
// response  out        rsp_valid/rsp_ready   rsp_data  (rsp_t)
//
// One transaction at a time. Query, refused insert and empty pop go straight
// to the response register. Pop takes a head step plus one slot memory read
// for the new head. Insert walks the stored events later than the new one,
// one slot per cycle with one read and one write of the slot memory, and
// writes the new event into the slot where the walk stops.
// Reset clears the count, pointers, output register occupancy and controller
// state; slot contents need no clearing. A new request is taken while an
// earlier response waits in the output register; a stalled response holds the controller in its final state.
module timed_event_priority_queue_top
	import tepq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req_data,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp_data
);

	cmd_t cmd;
	sts_t sts;

	tepq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_type (req_data.req_type),
		.sts      (sts),
		.req_ready(req_ready),
		.cmd      (cmd)
	);

	tepq_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_data (req_data),
		.cmd      (cmd),
		.sts      (sts),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_data (rsp_data)
	);

endmodule

// ----- sv/tepq_checker.sv -----
module tepq_checker
	import tepq_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp_data
);

	// Empty flag agrees with the count
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_data.is_empty == (rsp_data.entry_total == '0)))
		else $error("is_empty disagrees with entry_total");

	// No event reported means zero fields
	a_no_event_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_data.out_valid) |->
		(rsp_data.out_kind == '0 && rsp_data.out_due == '0))
		else $error("fields not zero without a valid event");

	// A due head needs a stored event
	a_ready_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_data.head_ready) |-> !rsp_data.is_empty)
		else $error("head_ready on an empty queue");

	// A refused insert only happens on a full queue, whose head is reported
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_data.insert_dropped) |->
		(rsp_data.entry_total == CNT_FULL && rsp_data.out_valid))
		else $error("insert dropped while not full");

	// Stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
		else $error("response changed while stalled");

endmodule

bind timed_event_priority_queue_top tepq_checker u_tepq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp_data (rsp_data)
);

// ----- verif/tb_timed_event_priority_queue_top.sv -----
`timescale 1ns / 100ps

module tb_timed_event_priority_queue_top
	import tepq_pkg::*;
();

	// Spare request code, handled by the block like a query
	localparam logic [1:0] REQ_SPARE = 2'd3;

	localparam int RANDOM_ITEMS  = 1450;
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT   = 400000;

	logic clk;
	logic arst_n;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req_data  = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp_data;

	// Shadow copy of the sorted event store
	logic [TIME_BITS-1:0] shadow_due [CAPACITY];
	logic [KIND_BITS-1:0] shadow_kind [CAPACITY];
	int shadow_cnt = 0;

	req_t req_backlog [$];
	bit   drain_first [$];
	rsp_t rsp_pending [$];

	int n_accepted = 0;
	int n_checked  = 0;
	int fail_cnt   = 0;
	int cycle_cnt  = 0;
	int send_gap   = 0;
	int stall_left = 0;
	int stall_draw;
	bit send_eager = 1'b0;
	bit recv_eager = 1'b0;
	rsp_t rsp_pred;
	rsp_t rsp_want;

	timed_event_priority_queue_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

	// Apply one request to the shadow store and build its response
	task automatic predict_queue_op(input req_t rq, output rsp_t rs);
		int pos;
		rs = '0;
		if (rq.req_type == REQ_INSERT) begin
			if (shadow_cnt >= CAPACITY) begin
				rs.insert_dropped = 1'b1;
			end else begin
				// new event goes behind all equal or earlier times
				pos = 0;
				while (pos < shadow_cnt && shadow_due[pos] <= rq.event_due)
					pos++;
				for (int i = shadow_cnt; i > pos; i--) begin
					shadow_due[i]  = shadow_due[i-1];
					shadow_kind[i] = shadow_kind[i-1];
				end
				shadow_due[pos]  = rq.event_due;
				shadow_kind[pos] = rq.event_kind;
				shadow_cnt++;
			end
		end
		if (rq.req_type == REQ_POP) begin
			if (shadow_cnt > 0) begin
				rs.out_valid = 1'b1;
				rs.out_kind  = shadow_kind[0];
				rs.out_due   = shadow_due[0];
				for (int i = 1; i < shadow_cnt; i++) begin
					shadow_due[i-1]  = shadow_due[i];
					shadow_kind[i-1] = shadow_kind[i];
				end
				shadow_cnt--;
			end
		end else if (shadow_cnt > 0) begin
			rs.out_valid = 1'b1;
			rs.out_kind  = shadow_kind[0];
			rs.out_due   = shadow_due[0];
		end
		rs.head_ready  = (shadow_cnt > 0) && (shadow_due[0] <= rq.now_time);
		rs.entry_total = CNT_BITS'(shadow_cnt);
		rs.is_empty    = (shadow_cnt == 0);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_cnt++;
		end
	endtask

	task automatic add_item(input logic [1:0] op, input logic [KIND_BITS-1:0] kind,
			input logic [TIME_BITS-1:0] due, input logic [TIME_BITS-1:0] now,
			input bit wait_idle);
		req_t item;
		item.req_type   = op;
		item.event_kind = kind;
		item.event_due  = due;
		item.now_time   = now;
		req_backlog.push_back(item);
		drain_first.push_back(wait_idle);
	endtask

	// Times cluster around a per-phase base so ties and near-misses are common
	function automatic logic [31:0] pick_time(input logic [31:0] base);
		int sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0: return '0;
			1: return '1;
			2, 3, 4: return $urandom();
			default: return base + $urandom_range(0, 15);
		endcase
	endfunction

	// Clock
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Reset
	initial begin
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req_data  <= '0;
			send_gap  <= 0;
		end else begin
			// transaction accepted: predict its response
			if (req_valid && req_ready) begin
				predict_queue_op(req_data, rsp_pred);
				rsp_pending.push_back(rsp_pred);
				n_accepted++;
			end
			if (!req_valid || req_ready) begin
				if (send_gap != 0) begin
					send_gap  <= send_gap - 1;
					req_valid <= 1'b0;
				end else if (req_backlog.size() != 0 &&
						!(drain_first[0] && n_accepted != n_checked)) begin
					req_data  <= req_backlog.pop_front();
					void'(drain_first.pop_front());
					req_valid <= 1'b1;
					if ($urandom_range(0, 39) == 0)
						send_eager = !send_eager;
					send_gap <= send_eager ? 0 : $urandom_range(0, 19);
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Response monitor and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready  <= 1'b0;
			stall_left <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (rsp_pending.size() == 0) begin
					$error("response transaction with no request outstanding");
					fail_cnt++;
				end else begin
					rsp_want = rsp_pending.pop_front();
					check_field("out_valid", 32'(rsp_want.out_valid),
						32'(rsp_data.out_valid));
					check_field("out_kind", 32'(rsp_want.out_kind),
						32'(rsp_data.out_kind));
					check_field("out_due", rsp_want.out_due, rsp_data.out_due);
					check_field("head_ready", 32'(rsp_want.head_ready),
						32'(rsp_data.head_ready));
					check_field("entry_total", 32'(rsp_want.entry_total),
						32'(rsp_data.entry_total));
					check_field("is_empty", 32'(rsp_want.is_empty),
						32'(rsp_data.is_empty));
					check_field("insert_dropped", 32'(rsp_want.insert_dropped),
						32'(rsp_data.insert_dropped));
					n_checked <= n_checked + 1;
				end
				if ($urandom_range(0, 39) == 0)
					recv_eager = !recv_eager;
				stall_draw = recv_eager ? 0 : $urandom_range(0, 19);
				stall_left <= stall_draw;
				rsp_ready  <= (stall_draw == 0);
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				rsp_ready  <= (stall_left == 1);
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Stimulus and end of run
	initial begin
		int phase_kind;
		int phase_len;
		int roll;
		int ins_pct;
		int pop_pct;
		int n_random;
		logic [1:0] op;
		logic [31:0] base;

		// empty queue: query, pop, spare code
		add_item(REQ_QUERY, 8'h00, '0, '0, 1'b0);
		add_item(REQ_POP, 8'hFF, '1, '1, 1'b0);
		add_item(REQ_SPARE, 8'h3C, 32'h1234_5678, '1, 1'b0);
		// time extremes and a tie
		add_item(REQ_INSERT, 8'h00, '1, '0, 1'b0);
		add_item(REQ_INSERT, 8'hFF, '0, '0, 1'b0);
		add_item(REQ_INSERT, 8'h5A, 32'h0001_0000, 32'h0000_FFFF, 1'b0);
		add_item(REQ_INSERT, 8'hA5, 32'h0001_0000, 32'h0001_0000, 1'b0);
		add_item(REQ_QUERY, 8'h00, '0, '0, 1'b0);
		add_item(REQ_POP, 8'h00, '0, '0, 1'b0);
		add_item(REQ_QUERY, 8'h00, '0, 32'h0000_FFFF, 1'b0);
		// fill with more equal times to check arrival order, then overflow
		for (int i = 0; i < 13; i++)
			add_item(REQ_INSERT, 8'(i + 1), 32'h0001_0000, 32'h0001_0000, 1'b0);
		add_item(REQ_INSERT, 8'h77, '0, '1, 1'b0);
		add_item(REQ_SPARE, 8'h00, '0, '1, 1'b0);

		// Random phases: fill-heavy, drain-heavy and mixed
		n_random = 0;
		while (n_random < RANDOM_ITEMS) begin
			phase_kind = $urandom_range(0, 2);
			phase_len  = $urandom_range(8, 48);
			base       = $urandom_range(0, 32'hFFFF_FF00);
			case (phase_kind)
				0: begin
					ins_pct = 80;
					pop_pct = 10;
				end
				1: begin
					ins_pct = 12;
					pop_pct = 75;
				end
				default: begin
					ins_pct = 45;
					pop_pct = 30;
				end
			endcase
			repeat (phase_len) begin
				roll = $urandom_range(0, 99);
				if (roll < ins_pct)
					op = REQ_INSERT;
				else if (roll < ins_pct + pop_pct)
					op = REQ_POP;
				else if (roll < 97)
					op = REQ_QUERY;
				else
					op = REQ_SPARE;
				add_item(op, 8'($urandom_range(0, 255)), pick_time(base), pick_time(base),
					n_random == 0 || $urandom_range(0, 149) == 0);
				n_random++;
			end
		end

		// Wait for every response, then let the block settle
		do
			@(negedge clk);
		while (req_backlog.size() != 0 || req_valid || n_checked != n_accepted);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (rsp_pending.size() != 0) begin
			$error("%0d expected responses never arrived", rsp_pending.size());
			fail_cnt++;
		end
		if (fail_cnt == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
